FILE: src/csfv_pkg.sv
// ----------------------------------------------------------------------------
// csfv_pkg
// Shared types, constants and elaboration-time trig helpers for the cube
// sphere face vertex core.
// ----------------------------------------------------------------------------
package csfv_pkg;

  // Grid and angle constants.
  localparam int unsigned MAX_SUB         = 8;
  localparam int unsigned COORD_FRAC_BITS = 12;
  localparam int unsigned IDX_HALF        = 128;              // 45 degrees in grid steps
  localparam int unsigned TAB_DEPTH       = IDX_HALF + 1;
  localparam int unsigned ANG_STEP        = 1 << (16 - MAX_SUB);
  localparam logic [63:0] PI_Q29          = 64'd1686629713;
  localparam logic [63:0] Q30_ONE         = 64'd1 << 30;

  // Pipeline geometry: one stage per root bit and per quotient bit.
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 16;
  localparam int unsigned ST_A     = 0;
  localparam int unsigned ST_B     = 1;
  localparam int unsigned ST_C     = 2;
  localparam int unsigned ST_D     = 3;
  localparam int unsigned ST_E     = 4;
  localparam int unsigned ST_SQ0   = 5;
  localparam int unsigned ST_M1    = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_M2    = ST_M1 + 1;
  localparam int unsigned ST_DV0   = ST_M2 + 1;
  localparam int unsigned ST_O     = ST_DV0 + DV_STEPS;
  localparam int unsigned NST      = ST_O + 1;

  // Configuration register byte addresses.
  localparam logic [2:0] ADDR_SUBDIV = 3'd0;
  localparam logic [2:0] ADDR_RADIUS = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [3:0]  SUBDIV_RST = 4'd3;
  localparam logic [15:0] RADIUS_RST = 16'd4096;

  // Data carried along the pipeline.
  typedef struct packed {
    logic              clamped;
    logic              lat_neg;
    logic              lon_neg;
    logic [7:0]        lat_idx;
    logic [7:0]        lon_idx;
    logic [30:0]       s1;
    logic [30:0]       c1;
    logic [30:0]       s2;
    logic [30:0]       c2;
    logic [2:0][30:0]  v;
    logic [2:0][61:0]  sq;
    logic [63:0]       rem;
    logic [63:0]       root;
    logic [2:0][47:0]  num;
    logic [2:0][15:0]  q;
    logic [2:0][16:0]  crd;
  } pl_t;

  // Angle magnitude in units of 90/65536 degree to radians in Q30.
  function automatic logic [63:0] ang_rad(input logic [63:0] mag);
    return (mag * PI_Q29) >> 16;
  endfunction

  // Truncated Taylor sine in Q30.
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // Truncated Taylor cosine in Q30.
  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    return Q30_ONE - ((x2 * t) >> 30) / 64'd2;
  endfunction

endpackage

FILE: src/cube_sphere_face_vertex_core.sv
// Throughput: one item per cycle while the output is not stalled; the square root
// takes one stage per root bit (32 stages) and each divider one stage per quotient
// bit (16 stages).
// A stall freezes every stage; a two-entry path (input skid plus output register)
// keeps in_tready independent of out_tready.
// Reset (synchronous, rst_n low) clears all valid bits and loads subdivision 3, radius 1.0.
// ----------------------------------------------------------------------------
// cube_sphere_face_vertex_core
// Maps a row and column index on the +X cube face grid to a sphere vertex in
// Q4.12, through sin/cos tables, a pipelined square root and dividers.
// ----------------------------------------------------------------------------
module cube_sphere_face_vertex_core
  import csfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // row_index[8:0], column_index[17:9], zero pad
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // x_coord[16:0], y_coord[33:17], z_coord[50:34],
                                   // index_clamped[51], zero pad
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0]  subdiv_r;
  logic [15:0] radius_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= SUBDIV_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == ADDR_SUBDIV) subdiv_r <= cfg_pwdata[3:0];
      if (cfg_paddr == ADDR_RADIUS) radius_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_SUBDIV) cfg_prdata = {28'd0, subdiv_r};
    if (cfg_paddr == ADDR_RADIUS) cfg_prdata = {16'd0, radius_r};
  end

  // Sine and cosine tables over the 129 reachable angle magnitudes.
  logic [30:0] sin_tab [TAB_DEPTH];
  logic [30:0] cos_tab [TAB_DEPTH];

  for (genvar t = 0; t < TAB_DEPTH; t++) begin : g_tab
    localparam logic [63:0] RAD = ang_rad(64'(t) * 64'(ANG_STEP));
    assign sin_tab[t] = 31'(sin_q30(RAD));
    assign cos_tab[t] = 31'(cos_q30(RAD));
  end

  // Pipeline enable and input skid buffer.
  logic        en;
  logic        skid_v_r;
  logic [17:0] skid_d_r;
  logic        src_vld;
  logic [8:0]  src_row;
  logic [8:0]  src_col;
  logic [NST-1:0] vld_r;
  pl_t         st_r   [NST];
  pl_t         st_nxt [NST];

  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = !skid_v_r;
  assign src_vld   = skid_v_r || in_tvalid;
  assign src_row   = skid_v_r ? skid_d_r[8:0]  : in_tdata[8:0];
  assign src_col   = skid_v_r ? skid_d_r[17:9] : in_tdata[17:9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_tvalid && in_tready) skid_d_r <= in_tdata[17:0];
  end

  // Stage logic.
  for (genvar g = 0; g < NST; g++) begin : g_st
    if (g == ST_A) begin : g_a
      // Clamp indices and fold both angles into magnitude and sign.
      logic [3:0] s_eff;
      logic [8:0] n_pts;
      logic [8:0] row_c;
      logic [8:0] col_c;
      logic [8:0] ridx;
      logic [8:0] cidx;
      always_comb begin
        s_eff = (subdiv_r > 4'(MAX_SUB)) ? 4'(MAX_SUB) : subdiv_r;
        n_pts = 9'd1 << s_eff;
        row_c = (src_row > n_pts) ? n_pts : src_row;
        col_c = (src_col > n_pts) ? n_pts : src_col;
        ridx  = row_c << (4'(MAX_SUB) - s_eff);
        cidx  = col_c << (4'(MAX_SUB) - s_eff);
        st_nxt[g]         = '0;
        st_nxt[g].clamped = (src_row > n_pts) || (src_col > n_pts);
        if (ridx <= 9'(IDX_HALF)) begin
          st_nxt[g].lat_idx = 8'(9'(IDX_HALF) - ridx);
          st_nxt[g].lat_neg = 1'b0;
        end else begin
          st_nxt[g].lat_idx = 8'(ridx - 9'(IDX_HALF));
          st_nxt[g].lat_neg = 1'b1;
        end
        if (cidx >= 9'(IDX_HALF)) begin
          st_nxt[g].lon_idx = 8'(cidx - 9'(IDX_HALF));
          st_nxt[g].lon_neg = 1'b0;
        end else begin
          st_nxt[g].lon_idx = 8'(9'(IDX_HALF) - cidx);
          st_nxt[g].lon_neg = 1'b1;
        end
      end
    end else if (g == ST_B) begin : g_b
      // Table lookups.
      always_comb begin
        st_nxt[g]    = st_r[g-1];
        st_nxt[g].s1 = sin_tab[st_r[g-1].lon_idx];
        st_nxt[g].c1 = cos_tab[st_r[g-1].lon_idx];
        st_nxt[g].s2 = sin_tab[st_r[g-1].lat_idx];
        st_nxt[g].c2 = cos_tab[st_r[g-1].lat_idx];
      end
    end else if (g == ST_C) begin : g_c
      // Direction components as Q30 products.
      logic [61:0] p0, p1, p2;
      always_comb begin
        p0 = 62'(st_r[g-1].c1) * 62'(st_r[g-1].c2);
        p1 = 62'(st_r[g-1].c1) * 62'(st_r[g-1].s2);
        p2 = 62'(st_r[g-1].s1) * 62'(st_r[g-1].c2);
        st_nxt[g]      = st_r[g-1];
        st_nxt[g].v[0] = p0[60:30];
        st_nxt[g].v[1] = p1[60:30];
        st_nxt[g].v[2] = p2[60:30];
      end
    end else if (g == ST_D) begin : g_d
      // Squares of the components.
      always_comb begin
        st_nxt[g] = st_r[g-1];
        for (int i = 0; i < 3; i++) begin
          st_nxt[g].sq[i] = 62'(st_r[g-1].v[i]) * 62'(st_r[g-1].v[i]);
        end
      end
    end else if (g == ST_E) begin : g_e
      // Sum of squares seeds the square root.
      always_comb begin
        st_nxt[g]      = st_r[g-1];
        st_nxt[g].rem  = 64'(st_r[g-1].sq[0]) + 64'(st_r[g-1].sq[1])
                       + 64'(st_r[g-1].sq[2]);
        st_nxt[g].root = '0;
      end
    end else if (g >= ST_SQ0 && g < ST_M1) begin : g_sq
      // One root bit per stage.
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (g - ST_SQ0));
      logic [63:0] trial;
      always_comb begin
        trial     = st_r[g-1].root + BIT;
        st_nxt[g] = st_r[g-1];
        if (st_r[g-1].rem >= trial) begin
          st_nxt[g].rem  = st_r[g-1].rem - trial;
          st_nxt[g].root = (st_r[g-1].root >> 1) + BIT;
        end else begin
          st_nxt[g].root = st_r[g-1].root >> 1;
        end
      end
    end else if (g == ST_M1) begin : g_m1
      // Scale each magnitude by the radius.
      always_comb begin
        st_nxt[g] = st_r[g-1];
        for (int i = 0; i < 3; i++) begin
          st_nxt[g].num[i] = 48'(st_r[g-1].v[i]) * 48'(radius_r);
        end
      end
    end else if (g == ST_M2) begin : g_m2
      // Add half the length for rounding.
      always_comb begin
        st_nxt[g] = st_r[g-1];
        for (int i = 0; i < 3; i++) begin
          st_nxt[g].num[i] = st_r[g-1].num[i] + 48'(st_r[g-1].root[30:1]);
          st_nxt[g].q[i]   = '0;
        end
      end
    end else if (g >= ST_DV0 && g < ST_O) begin : g_dv
      // One quotient bit per stage for all three components.
      localparam int unsigned QB = DV_STEPS - 1 - (g - ST_DV0);
      logic [47:0] dsor;
      always_comb begin
        dsor      = 48'(st_r[g-1].root[30:0]) << QB;
        st_nxt[g] = st_r[g-1];
        for (int i = 0; i < 3; i++) begin
          if (st_r[g-1].num[i] >= dsor) begin
            st_nxt[g].num[i]   = st_r[g-1].num[i] - dsor;
            st_nxt[g].q[i][QB] = 1'b1;
          end
        end
      end
    end else begin : g_o
      // Apply signs; a zero length yields the origin.
      logic [2:0][16:0] mag;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          mag[i] = (st_r[g-1].root == '0) ? 17'd0 : {1'b0, st_r[g-1].q[i]};
        end
        st_nxt[g]        = st_r[g-1];
        st_nxt[g].crd[0] = mag[0];
        st_nxt[g].crd[1] = st_r[g-1].lat_neg ? 17'(-mag[1]) : mag[1];
        st_nxt[g].crd[2] = st_r[g-1].lon_neg ? mag[2] : 17'(-mag[2]);
      end
    end
  end

  // Stage registers: valid bits reset, payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], src_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
  end

  // Result channel.
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {4'd0, st_r[NST-1].clamped, st_r[NST-1].crd[2],
                       st_r[NST-1].crd[1], st_r[NST-1].crd[0]};

endmodule

FILE: src/csfv_checker.sv
// ----------------------------------------------------------------------------
// csfv_checker
// Port-level checks of the cube sphere face vertex core, bound to the top.
// ----------------------------------------------------------------------------
module csfv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        cfg_pready
);

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The x coordinate lies on the +X face and is never negative.
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[16])
    else $error("negative x coordinate");

  // The configuration port never waits.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind cube_sphere_face_vertex_core csfv_checker u_csfv_checker (.*);

FILE: bench/cube_sphere_face_vertex_checker.sv
// ----------------------------------------------------------------------------
// Cube sphere face vertex checker
// Watches the configuration port and both item channels. It predicts each
// vertex from the accepted index pair and the current register values, then
// compares every result item with the oldest pending vertex.
// ----------------------------------------------------------------------------
module cube_sphere_face_vertex_checker
  import csfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_vertices
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        clamped;
    logic [16:0] z;
    logic [16:0] y;
    logic [16:0] x;
  } vertex_t;

  localparam logic [63:0] UNIT = 64'd1 << 30;

  logic [3:0]  subdiv_q;
  logic [15:0] radius_q;
  vertex_t     vertex_q[$];

  // Sine of a Q30 angle in radians, series to the seventh power.
  function automatic logic [63:0] sine_q30(input logic [63:0] a);
    logic [63:0] a2, t;
    a2 = (a * a) >> 30;
    t  = UNIT - a2 / 64'd42;
    t  = UNIT - ((a2 * t) >> 30) / 64'd20;
    t  = UNIT - ((a2 * t) >> 30) / 64'd6;
    return (a * t) >> 30;
  endfunction

  // Cosine of a Q30 angle in radians, series to the eighth power.
  function automatic logic [63:0] cosine_q30(input logic [63:0] a);
    logic [63:0] a2, t;
    a2 = (a * a) >> 30;
    t  = UNIT - a2 / 64'd56;
    t  = UNIT - ((a2 * t) >> 30) / 64'd30;
    t  = UNIT - ((a2 * t) >> 30) / 64'd12;
    return UNIT - ((a2 * t) >> 30) / 64'd2;
  endfunction

  // Floor of the square root, one result bit per pass.
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales one direction component to the radius, rounded and saturated.
  function automatic logic [16:0] to_coord(input logic [63:0] mag, input logic [63:0] len,
                                           input logic neg);
    logic [63:0] q;
    if (len == 0) return '0;
    q = (mag * radius_q + len / 2) / len;
    if (q > 64'd65535) q = 64'd65535;
    if (neg) q = 64'd0 - q;
    return q[16:0];
  endfunction

  // Vertex on the +X face for one index pair.
  function automatic vertex_t face_vertex(input logic [8:0] row_in, input logic [8:0] col_in);
    vertex_t     v;
    int unsigned lvl, n, row, col, r, c, lat_mag, lon_mag;
    logic        lat_neg, lon_neg;
    logic [63:0] s1, c1, s2, c2, d0, d1, d2, len;
    lvl = (subdiv_q > MAX_SUB) ? MAX_SUB : subdiv_q;
    n   = 1 << lvl;
    row = row_in;
    col = col_in;
    v.clamped = 1'b0;
    if (row > n) begin row = n; v.clamped = 1'b1; end
    if (col > n) begin col = n; v.clamped = 1'b1; end
    r = row << (16 - lvl);
    c = col << (16 - lvl);
    if (r <= 32768) begin lat_mag = 32768 - r; lat_neg = 1'b0; end
    else begin lat_mag = r - 32768; lat_neg = 1'b1; end
    if (c >= 32768) begin lon_mag = c - 32768; lon_neg = 1'b0; end
    else begin lon_mag = 32768 - c; lon_neg = 1'b1; end
    s1 = sine_q30((64'(lon_mag) * PI_Q29) >> 16);
    c1 = cosine_q30((64'(lon_mag) * PI_Q29) >> 16);
    s2 = sine_q30((64'(lat_mag) * PI_Q29) >> 16);
    c2 = cosine_q30((64'(lat_mag) * PI_Q29) >> 16);
    d0  = (c1 * c2) >> 30;
    d1  = (c1 * s2) >> 30;
    d2  = (s1 * c2) >> 30;
    len = root_floor(d0 * d0 + d1 * d1 + d2 * d2);
    v.x = to_coord(d0, len, 1'b0);
    v.y = to_coord(d1, len, lat_neg);
    v.z = to_coord(d2, len, !lon_neg);
    return v;
  endfunction

  assign pending_vertices = vertex_q.size();

  // Register shadow, prediction on input items, comparison on result items.
  always @(posedge clk) begin
    vertex_t want, got;
    if (!rst_n) begin
      subdiv_q   <= SUBDIV_RST;
      radius_q   <= RADIUS_RST;
      fail_count <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_SUBDIV) subdiv_q <= cfg_pwdata[3:0];
        else if (cfg_paddr == ADDR_RADIUS) radius_q <= cfg_pwdata[15:0];
      end
      if (in_tvalid && in_tready) begin
        vertex_q = {vertex_q, face_vertex(in_tdata[8:0], in_tdata[17:9])};
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[51:0];
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = vertex_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.clamped !== want.clamped) begin
            $display("%0t: vertex mismatch expected x=%h y=%h z=%h clamped=%b",
                     $time, want.x, want.y, want.z, want.clamped);
            $display("%0t:                 actual   x=%h y=%h z=%h clamped=%b",
                     $time, got.x, got.y, got.z, got.clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_cube_sphere_face_vertex_core.sv
// ----------------------------------------------------------------------------
// Cube sphere face vertex core testbench
// Runs the core through a series of subdivision and radius settings with
// corner indices, clamped indices and random index pairs, under random idle
// and stall bursts plus one long output hold-off. The checker predicts and
// compares every vertex.
// ----------------------------------------------------------------------------
module tb_cube_sphere_face_vertex_core;
  import csfv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // row_index[8:0], column_index[17:9], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // x_coord[16:0], y_coord[33:17], z_coord[50:34],
                                  // index_clamped[51], zero pad
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending_vertices;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  cube_sphere_face_vertex_core DUT (.*);

  cube_sphere_face_vertex_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_pready, .fail_count, .pending_vertices);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop for a hung run.
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts and one long hold-off on request.
  initial begin
    int unsigned held;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Offers one index pair and waits until the core takes it.
  task automatic send_indices(input logic [8:0] row, input logic [8:0] col);
    bit taken;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, col, row};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Waits until every vertex has come back and the pipeline has drained.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_vertices != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Corners, centre and out-of-grid indices for the current grid size.
  task automatic send_corners(input int unsigned n);
    send_indices(9'd0, 9'd0);
    send_indices(9'(n), 9'(n));
    send_indices(9'd0, 9'(n));
    send_indices(9'(n), 9'd0);
    send_indices(9'(n / 2), 9'(n / 2));
    send_indices(9'(n + 1), 9'd0);
    send_indices(9'd0, 9'(n + 1));
    send_indices(9'h1FF, 9'h1FF);
  endtask

  initial begin
    int unsigned lvl_tab[10] = '{0, 8, 15, 5, 1, 8, 4, 7, 2, 6};
    int unsigned rad_tab[10] = '{4096, 65535, 12345, 0, 1, 4096, 0, 0, 40000, 4096};
    int unsigned lvl, n, rad, r, c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: directed indices including alternating bit patterns.
    send_corners(8);
    send_indices(9'h155, 9'h0AA);
    send_indices(9'h0AA, 9'h155);
    send_indices(9'h100, 9'h100);
    send_indices(9'd1, 9'd7);
    send_indices(9'd7, 9'd1);
    drain();

    for (int p = 0; p < 10; p++) begin
      lvl = lvl_tab[p];
      rad = (rad_tab[p] == 0 && p > 4) ? $urandom_range(0, 65535) : rad_tab[p];
      n   = 1 << ((lvl > MAX_SUB) ? MAX_SUB : lvl);
      quiet = (p == 9);
      write_reg(ADDR_SUBDIV, lvl);
      write_reg(ADDR_RADIUS, rad);
      if (p == 1) hold_request = 1'b1;
      send_corners(n);
      for (int k = 0; k < 175; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, 511);
          c = $urandom_range(0, 511);
        end else begin
          r = $urandom_range(0, n);
          c = $urandom_range(0, n);
        end
        send_indices(9'(r), 9'(c));
      end
      drain();
    end

    if (fail_count == 0 && pending_vertices == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: cube_sphere_face_vertex_core.f
src/csfv_pkg.sv
src/cube_sphere_face_vertex_core.sv
src/csfv_checker.sv
bench/cube_sphere_face_vertex_checker.sv
bench/tb_cube_sphere_face_vertex_core.sv
